>>> rtl/scu_pkg.sv
// Shared types and constants for the sequence counter unwrap block.
// Holds the request, result and register structs and the register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scu_pkg;

	localparam int TIME_W     = 40;
	localparam int RAW_W      = 7;
	localparam int ROW_W      = 24;
	localparam int COUNT_W    = 48;
	localparam int THRESH_W   = 24;
	localparam int PERIOD_W   = 20;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	// worst case folds for a 7-bit stamp against the smallest modulus (15)
	localparam int RAW_FOLDS  = 8;

	localparam logic [ROW_W-1:0]    ROWS_MAX         = '1;
	localparam logic [THRESH_W-1:0] GAP_THRESH_RESET = THRESH_W'(200000);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET     = PERIOD_W'(20000);

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_CAMERA_SELECT = 2'd0,
		REG_GAP_THRESHOLD = 2'd1,
		REG_FRAME_PERIOD  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] row_time_us;
		logic              front_valid;
		logic [RAW_W-1:0]  front_sequence;
		logic              rear_valid;
		logic [RAW_W-1:0]  rear_sequence;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]   row_index;
		logic [COUNT_W-1:0] unwrapped_sequence;
		logic               long_gap;
	} out_item_t;

	typedef struct packed {
		logic                camera_select;
		logic [THRESH_W-1:0] gap_threshold_us;
		logic [PERIOD_W-1:0] frame_period_us;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/scu_cfg_regs.sv
// APB-style configuration registers for the sequence counter unwrap block.
// Depends on scu_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module scu_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [scu_pkg::ADDR_W-1:0] paddr,
	input  wire logic [scu_pkg::DATA_W-1:0] pwdata,
	output logic      [scu_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output scu_pkg::cfg_t                   cfg
);
	import scu_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_select    <= 1'b0;
			cfg_q.gap_threshold_us <= GAP_THRESH_RESET;
			cfg_q.frame_period_us  <= PERIOD_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_CAMERA_SELECT: cfg_q.camera_select    <= pwdata[0];
				REG_GAP_THRESHOLD: cfg_q.gap_threshold_us <= pwdata[THRESH_W-1:0];
				REG_FRAME_PERIOD:  cfg_q.frame_period_us  <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CAMERA_SELECT: prdata = DATA_W'(cfg_q.camera_select);
			REG_GAP_THRESHOLD: prdata = DATA_W'(cfg_q.gap_threshold_us);
			REG_FRAME_PERIOD:  prdata = DATA_W'(cfg_q.frame_period_us);
			default:           prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/scu_wrap_search.sv
// Wrap count search: steps one candidate delta per cycle through a shared
// abs-difference and compare unit, keeping the one closest to elapsed time.
// Depends on scu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module scu_wrap_search #(
	parameter int SEQUENCE_MODULUS = 128,
	parameter int MAX_WRAP_CYCLES  = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     start,
	input  wire logic [$clog2(SEQUENCE_MODULUS)-1:0]      base,
	input  wire logic [scu_pkg::TIME_W-1:0]               elapsed,
	input  wire logic [scu_pkg::PERIOD_W-1:0]             period,
	output logic                                          done,
	output logic [$clog2(SEQUENCE_MODULUS*(MAX_WRAP_CYCLES+1))-1:0] best
);
	import scu_pkg::*;

	localparam int CAND_W   = $clog2(SEQUENCE_MODULUS*(MAX_WRAP_CYCLES+1));
	localparam int SCALED_W = CAND_W + PERIOD_W;
	localparam int DIFF_W   = ((SCALED_W > TIME_W) ? SCALED_W : TIME_W) + 2;
	localparam int ERR_W    = DIFF_W - 1;
	localparam int CNT_W    = $clog2(MAX_WRAP_CYCLES+1);

	typedef enum logic [2:0] {
		SR_IDLE = 3'b001,
		SR_INIT = 3'b010,
		SR_SCAN = 3'b100
	} srch_state_t;

	srch_state_t           st_q;
	logic [SCALED_W-1:0]   scaled_q;
	logic [SCALED_W-1:0]   step_q;
	logic [TIME_W-1:0]     elapsed_q;
	logic [DIFF_W-1:0]     limit_q;
	logic [CAND_W-1:0]     cand_q;
	logic [CAND_W-1:0]     best_q;
	logic [ERR_W-1:0]      best_err_q;
	logic [CNT_W-1:0]      cyc_q;
	logic                  done_q;

	logic [DIFF_W-1:0]     diff;
	logic [ERR_W-1:0]      err;
	logic                  stop;

	// the one shared unit: |cand*period - elapsed|
	assign diff = DIFF_W'(scaled_q) - DIFF_W'(elapsed_q);
	assign err  = diff[DIFF_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
	assign stop = (DIFF_W'(scaled_q) > limit_q) || (cyc_q == CNT_W'(MAX_WRAP_CYCLES));

	assign done = done_q;
	assign best = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SR_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				SR_IDLE: if (start) st_q <= SR_INIT;
				SR_INIT: st_q <= SR_SCAN;
				SR_SCAN: begin
					if (stop) begin
						st_q   <= SR_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= SR_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			SR_IDLE: begin
				if (start) begin
					scaled_q  <= SCALED_W'(base) * SCALED_W'(period);
					step_q    <= SCALED_W'(SEQUENCE_MODULUS) * SCALED_W'(period);
					cand_q    <= CAND_W'(base);
					elapsed_q <= elapsed;
				end
			end
			SR_INIT: begin
				best_q     <= cand_q;
				best_err_q <= err;
				limit_q    <= DIFF_W'(elapsed_q) + DIFF_W'(step_q);
				cand_q     <= cand_q + CAND_W'(SEQUENCE_MODULUS);
				scaled_q   <= scaled_q + step_q;
				cyc_q      <= CNT_W'(1);
			end
			SR_SCAN: begin
				// strict compare: a tie keeps the smaller delta
				if (err < best_err_q) begin
					best_q     <= cand_q;
					best_err_q <= err;
				end
				if (!stop) begin
					cand_q   <= cand_q + CAND_W'(SEQUENCE_MODULUS);
					scaled_q <= scaled_q + step_q;
					cyc_q    <= cyc_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/sequence_counter_unwrap_core.sv
// Top level of the sequence counter unwrap block: request/result handshake,
// unwrap state and sequencer. Uses scu_pkg, scu_cfg_regs, scu_wrap_search.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------
//  in      | request   | in_valid/in_ready | in_data   (in_item_t)
//  out     | result    | out_valid/out_ready | out_data (out_item_t)
//  apb     | config    | psel/penable/pready | paddr, pwdata, prdata
//
// One request at a time. Invalid or out-of-order rows go from evaluation back
// to idle; a first stamp or a short step goes on to commit, which may wait on a
// full result register. A long gap adds the wrap search between evaluation and
// commit; it tries wrap candidates one at a time, at most MAX_WRAP_CYCLES+1
// with the base delta, through the single abs-difference unit in scu_wrap_search.
// Reset clears the unwrap state and row counter and sets the config registers to their reset values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sequence_counter_unwrap_core #(
	parameter int SEQUENCE_MODULUS = 128,
	parameter int MAX_WRAP_CYCLES  = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire scu_pkg::in_item_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output scu_pkg::out_item_t              out_data,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [scu_pkg::ADDR_W-1:0] paddr,
	input  wire logic [scu_pkg::DATA_W-1:0] pwdata,
	output logic      [scu_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import scu_pkg::*;

	localparam int BASE_W   = $clog2(SEQUENCE_MODULUS);
	localparam int CAND_W   = $clog2(SEQUENCE_MODULUS*(MAX_WRAP_CYCLES+1));
	localparam int WORK_W   = ((BASE_W > RAW_W) ? BASE_W : RAW_W) + 1;
	localparam int HALF_MOD = SEQUENCE_MODULUS / 2;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EVAL   = 4'b0010,
		S_SEARCH = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	function automatic logic [RAW_W-1:0] seq_mod(input logic [RAW_W-1:0] v);
		logic [RAW_W-1:0] r;
		r = v;
		for (int i = 0; i < RAW_FOLDS; i++) begin
			if (32'(r) >= SEQUENCE_MODULUS) r = r - RAW_W'(SEQUENCE_MODULUS);
		end
		return r;
	endfunction

	cfg_t cfg;

	state_t              state_q;
	logic [TIME_W-1:0]   time_q;
	logic [RAW_W-1:0]    raw_q;
	logic                valid_q;
	logic [ROW_W-1:0]    row_q;
	logic [ROW_W-1:0]    rows_seen_q;
	logic                has_prev_q;
	logic [RAW_W-1:0]    prev_raw_q;
	logic [TIME_W-1:0]   prev_time_q;
	logic [COUNT_W-1:0]  count_q;
	logic [CAND_W-1:0]   delta_q;
	logic                first_q;
	logic                gap_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [WORK_W-1:0]   rm, pm, base_w;
	logic [BASE_W-1:0]   base;
	logic [TIME_W:0]     tdiff;
	logic                long_gap;
	logic [PERIOD_W-1:0] period_eff;
	logic                srch_start;
	logic                srch_done;
	logic [CAND_W-1:0]   srch_best;
	logic                commit;
	logic [COUNT_W-1:0]  next_count;

	scu_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// forward modular delta from the previous stamp
	assign rm     = WORK_W'(seq_mod(raw_q));
	assign pm     = WORK_W'(seq_mod(prev_raw_q));
	assign base_w = (rm >= pm) ? (rm - pm) : (rm + WORK_W'(SEQUENCE_MODULUS) - pm);
	assign base   = BASE_W'(base_w);

	// backward or equal time never counts as a long gap
	assign tdiff    = {1'b0, time_q} - {1'b0, prev_time_q};
	assign long_gap = !tdiff[TIME_W] && (tdiff[TIME_W-1:0] > TIME_W'(cfg.gap_threshold_us));

	assign period_eff = (cfg.frame_period_us == '0) ? PERIOD_W'(1) : cfg.frame_period_us;
	assign srch_start = (state_q == S_EVAL) && valid_q && has_prev_q && long_gap;

	scu_wrap_search #(
		.SEQUENCE_MODULUS (SEQUENCE_MODULUS),
		.MAX_WRAP_CYCLES  (MAX_WRAP_CYCLES)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (srch_start),
		.base    (base),
		.elapsed (tdiff[TIME_W-1:0]),
		.period  (period_eff),
		.done    (srch_done),
		.best    (srch_best)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign commit     = (state_q == S_COMMIT) && (!out_valid_q || out_ready);
	assign next_count = first_q ? COUNT_W'(raw_q) : (count_q + COUNT_W'(delta_q));
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_seen_q <= '0;
			has_prev_q  <= 1'b0;
			prev_raw_q  <= '0;
			prev_time_q <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
						if (rows_seen_q != ROWS_MAX) rows_seen_q <= rows_seen_q + ROW_W'(1);
					end
				end
				S_EVAL: begin
					if (!valid_q) begin
						state_q <= S_IDLE;
					end else if (!has_prev_q) begin
						state_q <= S_COMMIT;
					end else if (long_gap) begin
						state_q <= S_SEARCH;
					end else if (base_w > WORK_W'(HALF_MOD)) begin
						// out-of-order row: no result, state untouched
						state_q <= S_IDLE;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_SEARCH: if (srch_done) state_q <= S_COMMIT;
				S_COMMIT: begin
					if (commit) begin
						state_q     <= S_IDLE;
						has_prev_q  <= 1'b1;
						prev_raw_q  <= raw_q;
						prev_time_q <= time_q;
						count_q     <= next_count;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_q  <= in_data.row_time_us;
			valid_q <= cfg.camera_select ? in_data.rear_valid : in_data.front_valid;
			raw_q   <= cfg.camera_select ? in_data.rear_sequence : in_data.front_sequence;
			row_q   <= rows_seen_q;
		end
		if (state_q == S_EVAL) begin
			first_q <= !has_prev_q;
			gap_q   <= has_prev_q && long_gap;
			delta_q <= CAND_W'(base);
		end
		if (srch_done) delta_q <= srch_best;
		if (commit) begin
			out_q.row_index          <= row_q;
			out_q.unwrapped_sequence <= next_count;
			out_q.long_gap           <= gap_q;
		end
	end

`ifndef ASSERT_OFF
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_COMMIT))
		else $error("result raised outside commit");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |-> (state_q == S_SEARCH))
		else $error("wrap search finished while not waited on");

	a_has_prev_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		has_prev_q |=> has_prev_q)
		else $error("previous stamp flag cleared");

	a_rows_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (rows_seen_q >= $past(rows_seen_q)))
		else $error("row counter went backwards");

	a_commit_keeps_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> !$past(commit))
		else $error("commit overwrote a waiting result");
`endif

endmodule

`default_nettype wire
